/* design/ats_pkg.sv */
// Package: shared types, pattern tables and lookup functions of the alarm tone sequencer.
`timescale 1ns / 1ps
package ats_pkg;

    // Sizing
    localparam int NUM_KINDS   = 10;
    localparam int MAX_STEPS   = 6;
    localparam int TABLE_KINDS = 10;
    localparam int STEP_ROWS   = 11;
    localparam int KIND_ACTIVE = (NUM_KINDS < TABLE_KINDS) ? NUM_KINDS : TABLE_KINDS;
    localparam int KIND_IW     = (KIND_ACTIVE > 1) ? $clog2(KIND_ACTIVE) : 1;

    localparam logic [7:0]  LOOP_FOREVER  = 8'd255;
    localparam logic [15:0] DEDUP_DEFAULT = 16'd8000;

    // Operation codes
    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_RAISE   = 2'd1,
        OP_SESSION = 2'd2,
        OP_STOP    = 2'd3
    } op_t;

    typedef struct packed {
        op_t         operation;
        logic [3:0]  alarm_kind;
        logic [31:0] now_time;
    } in_item_t;

    typedef struct packed {
        logic       tone_on;
        logic       busy_res;
        logic       raise_taken;
        logic       voice_due;
        logic [3:0] voice_kind;
        logic [1:0] playing_level;
    } out_item_t;

    typedef struct packed {
        logic [7:0] on;
        logic [7:0] off;
    } step_t;

    typedef struct packed {
        logic [3:0] first;
        logic [3:0] count;
        logic [1:0] level;
        logic [7:0] loops;
        logic       has_voice;
        logic       per_session;
    } kind_info_t;

    // On/off tick pattern rows
    localparam step_t STEP_ROM [STEP_ROWS] = '{
        '{8'd2, 8'd2}, '{8'd2, 8'd2}, '{8'd2, 8'd8},
        '{8'd2, 8'd2}, '{8'd2, 8'd2}, '{8'd2, 8'd0},
        '{8'd3, 8'd4}, '{8'd3, 8'd0},
        '{8'd1, 8'd0},
        '{8'd2, 8'd2}, '{8'd2, 8'd0}
    };

    // Per-kind pattern descriptor
    localparam kind_info_t KIND_ROM [TABLE_KINDS] = '{
        '{4'd0, 4'd6, 2'd3, 8'd0, 1'b1, 1'b0},
        '{4'd0, 4'd6, 2'd3, 8'd0, 1'b1, 1'b0},
        '{4'd6, 4'd2, 2'd2, 8'd0, 1'b1, 1'b1},
        '{4'd8, 4'd1, 2'd2, 8'd0, 1'b1, 1'b0},
        '{4'd6, 4'd2, 2'd2, 8'd0, 1'b0, 1'b1},
        '{4'd6, 4'd2, 2'd2, 8'd0, 1'b0, 1'b1},
        '{4'd8, 4'd1, 2'd1, 8'd0, 1'b1, 1'b0},
        '{4'd8, 4'd1, 2'd1, 8'd0, 1'b1, 1'b0},
        '{4'd9, 4'd2, 2'd1, 8'd0, 1'b1, 1'b1},
        '{4'd8, 4'd1, 2'd1, 8'd0, 1'b0, 1'b0}
    };

    // Descriptor of a kind; all zero beyond the table
    function automatic kind_info_t kind_lookup(input logic [3:0] kind);
        kind_info_t ki;
        ki = '0;
        if (kind < 4'(TABLE_KINDS))
            ki = KIND_ROM[kind];
        return ki;
    endfunction

    // Step of a kind's pattern; all zero past the pattern or the table
    function automatic step_t step_at(input logic [3:0] kind, input logic [2:0] idx);
        kind_info_t ki;
        logic [4:0] pos;
        step_t      s;
        s   = '0;
        ki  = kind_lookup(kind);
        pos = 5'(ki.first) + 5'(idx);
        if (kind < 4'(TABLE_KINDS) && 4'(idx) < ki.count && 4'(idx) < 4'(MAX_STEPS)
            && pos < 5'(STEP_ROWS))
            s = STEP_ROM[pos[3:0]];
        return s;
    endfunction

endpackage

/* design/ats_input_stage.sv */
// Input register: captures one item per transfer and hands it to the sequencing engine.
`timescale 1ns / 1ps
module ats_input_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  ats_pkg::in_item_t item,
    input  logic              fire,
    output logic              held_valid,
    output ats_pkg::in_item_t held_item
);
    import ats_pkg::*;

    logic     valid_reg;
    in_item_t item_reg;

    // Free when empty or when the held item is consumed this cycle
    assign item_ready = !valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            valid_reg <= item_valid;
        end
    end

    // Hold the payload until the engine consumes it
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

/* design/ats_seq_engine.sv */
// Sequencing engine: alarm state, dedup and session tables, and the per-item next-state logic.
`timescale 1ns / 1ps
module ats_seq_engine (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [15:0]        wr_data,
    input  logic               fire,
    input  ats_pkg::in_item_t  item,
    output ats_pkg::out_item_t res
);
    import ats_pkg::*;

    // Pattern state
    logic        playing_reg,  playing_next;
    logic [3:0]  kind_reg,     kind_next;
    logic [2:0]  step_reg,     step_next;
    logic        phase_reg,    phase_next;
    logic [7:0]  ticks_reg,    ticks_next;
    logic [7:0]  reps_reg,     reps_next;
    logic [4:0]  pend_reg,     pend_next;
    logic [15:0] window_reg;

    // Per-kind tables
    logic [31:0]            last_reg [KIND_ACTIVE];
    logic [KIND_ACTIVE-1:0] flags_reg, flags_next;
    logic                   last_we;

    logic [KIND_IW-1:0] kidx;
    logic               kind_ok;
    kind_info_t         cur_info, new_info, lvl_info;
    step_t              step_cur, step_nxt, step_first, new_first;
    logic [2:0]         nidx;
    logic               wrap;
    logic [31:0]        diff;
    logic               raise_ok;
    logic [4:0]         pend_new;
    logic               taken;
    logic               vdue;
    logic [3:0]         vkind;

    assign kidx    = item.alarm_kind[KIND_IW-1:0];
    assign kind_ok = item.alarm_kind < 4'(KIND_ACTIVE);

    always_comb
    begin
        playing_next = playing_reg;
        kind_next    = kind_reg;
        step_next    = step_reg;
        phase_next   = phase_reg;
        ticks_next   = ticks_reg;
        reps_next    = reps_reg;
        pend_next    = pend_reg;
        flags_next   = flags_reg;
        last_we      = 1'b0;
        taken        = 1'b0;
        vdue         = 1'b0;
        vkind        = '0;

        cur_info   = kind_lookup(kind_reg);
        new_info   = kind_lookup(item.alarm_kind);
        step_cur   = step_at(kind_reg, step_reg);
        nidx       = step_reg + 3'd1;
        step_nxt   = step_at(kind_reg, nidx);
        step_first = step_at(kind_reg, 3'd0);
        new_first  = step_at(item.alarm_kind, 3'd0);
        wrap       = (4'(nidx) >= cur_info.count) || (4'(nidx) >= 4'(MAX_STEPS))
                     || (nidx == 3'd0);
        diff       = item.now_time - last_reg[kidx];
        pend_new   = new_info.has_voice ? {1'b1, item.alarm_kind} : 5'd0;

        // Raise checks: dedup window, once per session, level priority
        raise_ok = kind_ok && (diff >= {16'd0, window_reg})
                   && !(new_info.per_session && flags_reg[kidx])
                   && !(playing_reg && kind_reg < 4'(TABLE_KINDS)
                        && new_info.level < cur_info.level);

        if (fire)
        begin
            unique case (item.operation)
                OP_TICK:
                begin
                    if (!playing_reg || kind_reg >= 4'(TABLE_KINDS))
                    begin
                        // Idle tick: clear the playing, step, phase, tick and repeat state
                        playing_next = 1'b0;
                        step_next    = '0;
                        phase_next   = 1'b0;
                        ticks_next   = '0;
                        reps_next    = '0;
                    end
                    else if (ticks_reg > 8'd1)
                    begin
                        ticks_next = ticks_reg - 8'd1;
                    end
                    else if (phase_reg && step_cur.off != 8'd0)
                    begin
                        // On phase over: enter the off phase
                        phase_next = 1'b0;
                        ticks_next = step_cur.off;
                    end
                    else if (!wrap)
                    begin
                        // Advance to the next step
                        step_next  = nidx;
                        phase_next = 1'b1;
                        ticks_next = step_nxt.on;
                        if (step_nxt.on == 8'd0)
                        begin
                            playing_next = 1'b0;
                            step_next    = '0;
                            phase_next   = 1'b0;
                            reps_next    = '0;
                        end
                    end
                    else if ((reps_reg == LOOP_FOREVER || reps_reg > 8'd1)
                             && step_first.on != 8'd0)
                    begin
                        // Restart the pattern for another pass
                        if (reps_reg != LOOP_FOREVER)
                            reps_next = reps_reg - 8'd1;
                        step_next  = '0;
                        phase_next = 1'b1;
                        ticks_next = step_first.on;
                    end
                    else
                    begin
                        // Pattern complete: release any pending voice
                        playing_next = 1'b0;
                        step_next    = '0;
                        phase_next   = 1'b0;
                        ticks_next   = '0;
                        reps_next    = '0;
                        pend_next    = '0;
                        vdue         = pend_reg[4];
                        vkind        = pend_reg[4] ? pend_reg[3:0] : 4'd0;
                    end
                end
                OP_RAISE:
                begin
                    if (raise_ok)
                    begin
                        taken        = 1'b1;
                        last_we      = 1'b1;
                        if (new_info.per_session)
                            flags_next[kidx] = 1'b1;
                        kind_next    = item.alarm_kind;
                        playing_next = 1'b1;
                        reps_next    = new_info.loops;
                        step_next    = '0;
                        phase_next   = 1'b1;
                        ticks_next   = new_first.on;
                        pend_next    = pend_new;
                        if (new_first.on == 8'd0)
                        begin
                            // Empty first step finishes at once
                            playing_next = 1'b0;
                            phase_next   = 1'b0;
                            reps_next    = '0;
                            pend_next    = '0;
                            vdue         = pend_new[4];
                            vkind        = pend_new[4] ? pend_new[3:0] : 4'd0;
                        end
                    end
                end
                OP_SESSION:
                begin
                    for (int k = 0; k < KIND_ACTIVE; k++)
                    begin
                        if (KIND_ROM[k].per_session)
                            flags_next[k] = 1'b0;
                    end
                end
                OP_STOP:
                begin
                    playing_next = 1'b0;
                    step_next    = '0;
                    phase_next   = 1'b0;
                    ticks_next   = '0;
                    reps_next    = '0;
                end
            endcase
        end

        lvl_info = kind_lookup(kind_next);

        res.tone_on       = phase_next;
        res.busy_res      = playing_next;
        res.raise_taken   = taken;
        res.voice_due     = vdue;
        res.voice_kind    = vkind;
        res.playing_level = (playing_next && kind_next < 4'(TABLE_KINDS)) ? lvl_info.level
                                                                          : 2'd0;
    end

    // Advance pattern state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            playing_reg <= 1'b0;
            kind_reg    <= '0;
            step_reg    <= '0;
            phase_reg   <= 1'b0;
            ticks_reg   <= '0;
            reps_reg    <= '0;
            pend_reg    <= '0;
            flags_reg   <= '0;
        end
        else
        begin
            playing_reg <= playing_next;
            kind_reg    <= kind_next;
            step_reg    <= step_next;
            phase_reg   <= phase_next;
            ticks_reg   <= ticks_next;
            reps_reg    <= reps_next;
            pend_reg    <= pend_next;
            flags_reg   <= flags_next;
        end
    end

    // Last accepted raise time per kind
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < KIND_ACTIVE; k++)
                last_reg[k] <= '0;
        end
        else if (last_we)
        begin
            last_reg[kidx] <= item.now_time;
        end
    end

    // Dedup window register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= DEDUP_DEFAULT;
        end
        else if (wr_en)
        begin
            window_reg <= wr_data;
        end
    end

endmodule

/* design/ats_output_stage.sv */
// Result register: holds one result until the downstream transfer completes.
`timescale 1ns / 1ps
module ats_output_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  ats_pkg::out_item_t res,
    output logic               result_valid,
    input  logic               result_ready,
    output ats_pkg::out_item_t result
);
    import ats_pkg::*;

    logic      valid_reg;
    out_item_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Load a fresh result whenever the engine consumes an item
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= res;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

/* design/alarm_tone_sequencer_core.sv */
// Top level of the alarm tone sequencer: input register, sequencing engine, result register.
`timescale 1ns / 1ps
// Usage:
//   item channel (item_valid/item_ready/item) carries one operation per transfer:
//   step tick, raise alarm, session start or stop. result channel
//   (result_valid/result_ready/result) returns exactly one result per item,
//   in order. wr_en/wr_data write the dedup window at any clock edge, no wait.
// Timing:
//   An item transferred is held in the input register until the engine consumes
//   it; its result is then loaded into the result register and offered from there.
//   One item per cycle is sustained while result_ready stays high; the whole operation
//   is one pass through the pattern ROM lookups and the 32-bit dedup subtract/compare.
// Stalls:
//   While result_ready is low the result holds; one further item may wait in
//   the input register, after which item_ready drops until the result moves.
// Reset:
//   rst_n low clears all pattern state, raise times, session flags, the pending
//   voice and both stage valids, and loads the dedup window with 8000.
//   There is no clearing pass; items are taken the first cycle after reset.
module alarm_tone_sequencer_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  ats_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output ats_pkg::out_item_t result,
    input  logic               wr_en,
    input  logic [15:0]        wr_data
);
    import ats_pkg::*;

    logic      held_valid;
    in_item_t  held_item;
    out_item_t res;
    logic      fire;

    // Consume the held item when the result register can take its result
    assign fire = held_valid && (!result_valid || result_ready);

    ats_input_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .fire       (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    ats_seq_engine u_eng (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_data (wr_data),
        .fire    (fire),
        .item    (held_item),
        .res     (res)
    );

    ats_output_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .fire         (fire),
        .res          (res),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

`ifndef NO_ASSERTIONS
    // A consumed item always leaves a result behind
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> result_valid)
        else $error("consumed item produced no result");

    // An accepted raise leaves a pattern playing or reports its voice at once
    a_taken_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.raise_taken) |-> (result.busy_res || result.voice_due))
        else $error("accepted raise left nothing playing");

    // Level is reported exactly while playing
    a_level_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.playing_level != 2'd0) == result.busy_res))
        else $error("playing level disagrees with busy flag");

    // A finished pattern is never still playing
    a_voice_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.voice_due) |-> (!result.busy_res && !result.tone_on))
        else $error("voice due while pattern still active");
`endif

endmodule
